/* rtl/core/chunked_slot_allocator_core_assert.svh */
// Assertion macros shared by the allocator core.
`ifndef CHUNKED_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define CHUNKED_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define CSA_ASSERT_ALWAYS(label, ck, rn, cond) \
	label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("csa: invariant violated");

// cons must hold in the same cycle as ante
`define CSA_ASSERT_IMPL(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("csa: same-cycle implication violated");

// cons must hold in the cycle after ante
`define CSA_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("csa: next-cycle implication violated");

`endif

/* rtl/core/csa_pkg.sv */
`default_nettype none

package csa_pkg;

	localparam int SLOTS_DEF       = 256;
	localparam int CHUNK_SLOTS_DEF = 16;

	// bitmap word scanned per cycle
	localparam int WORD_BITS = 16;
	localparam int BIT_W     = $clog2(WORD_BITS);

	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;
	localparam int CHUNKS_W = 5;
	localparam int FREE_W   = 9;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOC   = 2'd0,
		ST_FREED   = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic             down;
		logic             want_used;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
	} scan_req_t;

	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} scan_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/csa_if.sv */
`default_nettype none

interface csa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [csa_pkg::SLOT_W-1:0]  slot_in;

	modport source (output valid, kind, slot_in, input ready);
	modport sink   (input valid, kind, slot_in, output ready);
endinterface

interface csa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [csa_pkg::SLOT_W-1:0]    slot_out;
	logic [csa_pkg::STATUS_W-1:0]  status;
	logic [csa_pkg::CHUNKS_W-1:0]  active_chunks;
	logic [csa_pkg::FREE_W-1:0]    free_slots;

	modport source (output valid, slot_out, status, active_chunks, free_slots, input ready);
	modport sink   (input valid, slot_out, status, active_chunks, free_slots, output ready);
endinterface

`default_nettype wire

/* rtl/core/csa_bitmap.sv */
`default_nettype none

module csa_bitmap #(
	parameter int NWORDS = csa_pkg::SLOTS_DEF / csa_pkg::WORD_BITS,
	localparam int WA    = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [WA-1:0]                 rd_addr,
	output      logic [csa_pkg::WORD_BITS-1:0] rd_data,
	input  wire logic                          wr_en,
	input  wire logic [WA-1:0]                 wr_addr,
	input  wire logic [csa_pkg::WORD_BITS-1:0] wr_data
);

	logic [csa_pkg::WORD_BITS-1:0] mem_q [NWORDS];
	logic [NWORDS-1:0]             vld_q;
	logic [csa_pkg::WORD_BITS-1:0] rd_data_q;

	// a word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/csa_wscan.sv */
`default_nettype none

module csa_wscan (
	input  wire logic [csa_pkg::WORD_BITS-1:0] word,
	input  wire csa_pkg::scan_req_t            req,
	output      csa_pkg::scan_rsp_t            rsp
);

	localparam int W  = csa_pkg::WORD_BITS;
	localparam int BW = csa_pkg::BIT_W;

	logic [W-1:0] cand;

	always_comb begin
		cand = req.want_used ? word : ~word;
		for (int i = 0; i < W; i++) begin
			cand[i] = cand[i] && (BW'(i) >= req.lo) && (BW'(i) <= req.hi);
		end
	end

	// priority pick: lowest match going up, highest going down
	always_comb begin
		rsp = '0;
		if (req.down) begin
			for (int i = 0; i < W; i++) begin
				if (cand[i]) begin
					rsp.hit = 1'b1;
					rsp.pos = BW'(i);
				end
			end
		end else begin
			for (int i = W - 1; i >= 0; i--) begin
				if (cand[i]) begin
					rsp.hit = 1'b1;
					rsp.pos = BW'(i);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/chunked_slot_allocator_core.sv */
// Steps: a full pool or an out-of-range free goes straight to the result; chunk activation,
// alloc and free read one 16-slot bitmap word and scan further words as needed; freeing the
// top used slot also scans down for the new top and releases trailing chunks on the shrink.
// Throughput: one item at a time; the next beat is taken the cycle after the result
// is registered. The bitmap has a single read port, and scans go one word per cycle.
// Reset: all control registers clear and per-word valid flags clear at once; no clearing pass.
`default_nettype none
`include "chunked_slot_allocator_core_assert.svh"

module chunked_slot_allocator_core #(
	parameter int SLOTS       = csa_pkg::SLOTS_DEF,
	parameter int CHUNK_SLOTS = csa_pkg::CHUNK_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	csa_req_if.sink   req,
	csa_rsp_if.source rsp
);

	localparam int NCH    = SLOTS / CHUNK_SLOTS;
	localparam int SW     = $clog2(SLOTS + 1);
	localparam int CW     = $clog2(NCH + 1);
	localparam int W      = csa_pkg::WORD_BITS;
	localparam int BW     = csa_pkg::BIT_W;
	localparam int NWORDS = (SLOTS + W - 1) / W;
	localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int XW     = (SW > csa_pkg::SLOT_W) ? SW : csa_pkg::SLOT_W;

	localparam logic [SW-1:0] NONE  = SW'(SLOTS);
	localparam logic [SW-1:0] CSTEP = SW'(CHUNK_SLOTS);
	localparam logic [SW-1:0] CM1   = SW'(CHUNK_SLOTS - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_AWR  = 7'b0000010,
		S_SUP  = 7'b0000100,
		S_FCHK = 7'b0001000,
		S_SDN  = 7'b0010000,
		S_SHR  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [SW-1:0]    limit_q;
	logic [SW-1:0]    free_q;
	logic [SW-1:0]    lowest_q;
	logic [SW-1:0]    highest_q;
	logic [SW-1:0]    s_q;
	logic [SW-1:0]    h_q;
	logic             hnone_q;
	logic             act_q;
	logic             kind_q;
	logic [csa_pkg::SLOT_W-1:0] echo_q;
	csa_pkg::status_t st_q;
	logic [WA-1:0]    w_q;

	logic                          rsp_valid_q;
	logic [csa_pkg::SLOT_W-1:0]    slot_out_q;
	logic [csa_pkg::STATUS_W-1:0]  status_q;
	logic [csa_pkg::CHUNKS_W-1:0]  chunks_q;
	logic [csa_pkg::FREE_W-1:0]    free_out_q;

	logic              accept;
	logic [XW-1:0]     slot_ext;
	logic [XW-1:0]     limit_ext;
	logic [SW-1:0]     acc_slot;
	logic [WA-1:0]     s_word;
	logic [BW-1:0]     s_bit;
	logic [SW-1:0]     lm1;
	logic [WA-1:0]     last_w;
	logic [BW-1:0]     last_bit;
	logic [W-1:0]      bit_mask;
	logic [SW-1:0]     free_dec;
	logic              s_used;
	logic              fin_load;

	logic              rd_en;
	logic [WA-1:0]     rd_addr;
	logic [W-1:0]      rd_data;
	logic              wr_en;
	logic [WA-1:0]     wr_addr;
	logic [W-1:0]      wr_data;

	logic [W-1:0]        scan_word;
	csa_pkg::scan_req_t  scan_req;
	csa_pkg::scan_rsp_t  scan_rsp;
	logic                cont;
	logic [SW-1:0]       hit_slot_s;
	logic [SW-1:0]       hit_slot_w;

	csa_bitmap #(.NWORDS(NWORDS)) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	csa_wscan u_wscan (
		.word (scan_word),
		.req  (scan_req),
		.rsp  (scan_rsp)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign slot_ext  = XW'(req.slot_in);
	assign limit_ext = XW'(limit_q);
	assign s_word    = s_q[WA+BW-1:BW];
	assign s_bit     = s_q[BW-1:0];
	assign lm1       = limit_q - SW'(1);
	assign last_w    = lm1[WA+BW-1:BW];
	assign last_bit  = lm1[BW-1:0];
	assign bit_mask  = W'(1) << s_bit;
	assign free_dec  = (free_q != '0) ? free_q - SW'(1) : '0;
	assign s_used    = rd_data[s_bit];
	assign fin_load  = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);
	assign hit_slot_s = SW'({s_word, scan_rsp.pos});
	assign hit_slot_w = SW'({w_q, scan_rsp.pos});

	always_comb begin
		if (req.kind == csa_pkg::KIND_FREE) begin
			acc_slot = SW'(slot_ext);
		end else if (lowest_q < limit_q) begin
			acc_slot = lowest_q;
		end else begin
			acc_slot = limit_q;
		end
	end

	// shared word scanner: what it looks at depends on the step
	always_comb begin
		scan_word = rd_data;
		scan_req  = '0;
		case (state_q)
			S_AWR: begin
				scan_word          = rd_data | bit_mask;
				scan_req.lo        = s_bit;
				scan_req.hi        = (s_word == last_w) ? last_bit : '1;
			end
			S_SUP: begin
				scan_req.hi        = (w_q == last_w) ? last_bit : '1;
			end
			S_FCHK: begin
				scan_word          = rd_data & ~bit_mask;
				scan_req.down      = 1'b1;
				scan_req.want_used = 1'b1;
				scan_req.hi        = s_bit;
			end
			S_SDN: begin
				scan_req.down      = 1'b1;
				scan_req.want_used = 1'b1;
				scan_req.hi        = '1;
			end
			default: begin
				scan_req = '0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_AWR:   cont = !act_q && (free_dec != '0) && !scan_rsp.hit && (s_word != last_w);
			S_SUP:   cont = !scan_rsp.hit && (w_q != last_w);
			S_FCHK:  cont = s_used && (s_q == highest_q) && !scan_rsp.hit && (s_word != '0);
			S_SDN:   cont = !scan_rsp.hit && (w_q != '0);
			default: cont = 1'b0;
		endcase
	end

	// bitmap port: one read and one read-modify-write per cycle at most
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = s_word;
		wr_data = rd_data | bit_mask;
		case (state_q)
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = acc_slot[WA+BW-1:BW];
			end
			S_AWR: begin
				wr_en   = 1'b1;
				rd_en   = cont;
				rd_addr = s_word + WA'(1);
			end
			S_SUP: begin
				rd_en   = cont;
				rd_addr = w_q + WA'(1);
			end
			S_FCHK: begin
				wr_en   = s_used;
				wr_data = rd_data & ~bit_mask;
				rd_en   = cont;
				rd_addr = s_word - WA'(1);
			end
			S_SDN: begin
				rd_en   = cont;
				rd_addr = w_q - WA'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			limit_q   <= '0;
			free_q    <= '0;
			lowest_q  <= NONE;
			highest_q <= NONE;
			s_q       <= '0;
			h_q       <= '0;
			w_q       <= '0;
			echo_q    <= '0;
			act_q     <= 1'b0;
			hnone_q   <= 1'b0;
			kind_q    <= csa_pkg::KIND_ALLOC;
			st_q      <= csa_pkg::ST_ALLOC;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						s_q    <= acc_slot;
						kind_q <= req.kind;
						echo_q <= req.slot_in;
						act_q  <= 1'b0;
						if (req.kind == csa_pkg::KIND_FREE) begin
							if (slot_ext >= limit_ext) begin
								st_q    <= csa_pkg::ST_INVALID;
								state_q <= S_FIN;
							end else begin
								state_q <= S_FCHK;
							end
						end else if (lowest_q < limit_q) begin
							st_q    <= csa_pkg::ST_ALLOC;
							state_q <= S_AWR;
						end else if (count_q == CW'(NCH)) begin
							st_q    <= csa_pkg::ST_FULL;
							state_q <= S_FIN;
						end else begin
							act_q   <= 1'b1;
							st_q    <= csa_pkg::ST_ALLOC;
							state_q <= S_AWR;
						end
					end
				end
				S_AWR: begin
					if (act_q) begin
						highest_q <= s_q;
						lowest_q  <= s_q + SW'(1);
						count_q   <= count_q + CW'(1);
						limit_q   <= limit_q + CSTEP;
						free_q    <= free_q + CM1;
						state_q   <= S_FIN;
					end else begin
						if ((highest_q == NONE) || (s_q > highest_q)) begin
							highest_q <= s_q;
						end
						free_q <= free_dec;
						if ((free_dec != '0) && scan_rsp.hit) begin
							lowest_q <= hit_slot_s;
						end else begin
							lowest_q <= NONE;
						end
						w_q     <= s_word + WA'(1);
						state_q <= cont ? S_SUP : S_FIN;
					end
				end
				S_SUP: begin
					if (scan_rsp.hit) begin
						lowest_q <= hit_slot_w;
					end
					w_q     <= w_q + WA'(1);
					state_q <= cont ? S_SUP : S_FIN;
				end
				S_FCHK: begin
					if (!s_used) begin
						st_q    <= csa_pkg::ST_INVALID;
						state_q <= S_FIN;
					end else begin
						st_q   <= csa_pkg::ST_FREED;
						free_q <= free_q + SW'(1);
						if (s_q < lowest_q) begin
							lowest_q <= s_q;
						end
						if (s_q == highest_q) begin
							h_q     <= hit_slot_s;
							hnone_q <= !scan_rsp.hit;
							w_q     <= s_word - WA'(1);
							state_q <= cont ? S_SDN : S_SHR;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SDN: begin
					h_q     <= hit_slot_w;
					hnone_q <= !scan_rsp.hit;
					w_q     <= w_q - WA'(1);
					state_q <= cont ? S_SDN : S_SHR;
				end
				S_SHR: begin
					// drop one trailing chunk per cycle while it lies above the highest used slot
					if ((count_q != '0) &&
					    (hnone_q || ({1'b0, limit_q} > ({1'b0, h_q} + {1'b0, CSTEP})))) begin
						limit_q <= limit_q - CSTEP;
						count_q <= count_q - CW'(1);
						free_q  <= (free_q >= CSTEP) ? free_q - CSTEP : '0;
					end else begin
						if (count_q == '0) begin
							lowest_q  <= NONE;
							highest_q <= NONE;
							free_q    <= '0;
						end else begin
							highest_q <= h_q;
							if (lowest_q >= limit_q) begin
								lowest_q <= NONE;
							end
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register: holds a beat until taken, loads only from FIN
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			if (st_q == csa_pkg::ST_FULL) begin
				slot_out_q <= '0;
			end else if (kind_q == csa_pkg::KIND_FREE) begin
				slot_out_q <= echo_q;
			end else begin
				slot_out_q <= csa_pkg::SLOT_W'(s_q);
			end
			status_q   <= st_q;
			chunks_q   <= csa_pkg::CHUNKS_W'(count_q);
			free_out_q <= csa_pkg::FREE_W'(free_q);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.slot_out      = slot_out_q;
	assign rsp.status        = status_q;
	assign rsp.active_chunks = chunks_q;
	assign rsp.free_slots    = free_out_q;

	`CSA_ASSERT_ALWAYS(a_free_le_limit, clk, arst_n, free_q <= limit_q)
	`CSA_ASSERT_ALWAYS(a_limit_tracks_count, clk, arst_n, (32'(count_q) * CHUNK_SLOTS) == 32'(limit_q))
	`CSA_ASSERT_IMPL(a_highest_in_last_chunk, clk, arst_n, (state_q == S_IDLE) && (count_q != '0), (highest_q < limit_q) && ((32'(highest_q) + CHUNK_SLOTS) >= 32'(limit_q)))
	`CSA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != S_IDLE)

endmodule

`default_nettype wire
